[rtl/assert_macros.svh]
// Assertion macros shared by the damped-derivative PID RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define PDD_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define PDD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PDD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/pdd_pkg.sv]
// Shared widths, command codes and interface structs for the damped-derivative PID.
// No dependencies; used by pdd_dp, pdd_ctrl and pid_damped_derivative_unit.
package pdd_pkg;

  localparam int ErrW    = 16;
  localparam int GainW   = 16;
  localparam int LimW    = 23;
  localparam int IntegW  = 25;
  localparam int DiffW   = 17;
  localparam int DriveW  = 24;
  localparam int MulAW   = 25;
  localparam int MulBW   = 17;
  localparam int MulPW   = MulAW + MulBW;
  localparam int ProdPW  = 32;
  localparam int ProdIW  = 41;
  localparam int ProdDW  = 33;
  localparam int SqW     = 31;
  localparam int PiW     = 42;
  localparam int PiQW    = PiW - 8;
  localparam int QuoW    = 24;
  localparam int RemW    = 31;
  localparam int SumW    = 35;
  localparam int CntW    = 5;
  localparam int AddrW   = 5;
  localparam int DataW   = 32;

  localparam logic [CntW-1:0] MulLast = CntW'(3);
  localparam logic [CntW-1:0] DivLast = CntW'(QuoW - 1);
  localparam logic [LimW-1:0] LimReset = {LimW{1'b1}};

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_CLEAR,
    CMD_MUL,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_SUM,
    CMD_FINISH
  } cmd_op_t;

  typedef enum logic [1:0] {
    MUL_P,
    MUL_I,
    MUL_D,
    MUL_SQ
  } mul_sel_t;

  typedef struct packed {
    cmd_op_t  op;
    mul_sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } sts_t;

  typedef struct packed {
    logic signed [GainW-1:0] gain_p;
    logic signed [GainW-1:0] gain_i;
    logic signed [GainW-1:0] gain_d;
    logic [LimW-1:0]         output_limit;
    logic [LimW-1:0]         windup_limit;
  } cfg_t;

endpackage

[rtl/pdd_dp.sv]
// Datapath: integral/derivative state, shared multiplier, restoring divider, output clamp.
// Depends on pdd_pkg and assert_macros.svh; driven by commands from pdd_ctrl.
`include "assert_macros.svh"

module pdd_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  pdd_pkg::cmd_t                     cmd,
  output pdd_pkg::sts_t                     sts,
  input  pdd_pkg::cfg_t                     cfg,
  input  logic signed [pdd_pkg::ErrW-1:0]   error_in,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [pdd_pkg::DriveW-1:0]        m_tdata    // [23:0] drive
);

  logic signed [pdd_pkg::IntegW-1:0] integral;
  logic signed [pdd_pkg::ErrW-1:0]   last_error;
  logic signed [pdd_pkg::ErrW-1:0]   e_reg;
  logic signed [pdd_pkg::DiffW-1:0]  d_reg;
  logic signed [pdd_pkg::ProdPW-1:0] prod_p;
  logic signed [pdd_pkg::ProdIW-1:0] prod_i;
  logic signed [pdd_pkg::ProdDW-1:0] prod_d;
  logic [pdd_pkg::SqW-1:0]           prod_sq;
  logic signed [pdd_pkg::PiW-1:0]    pi_sum;
  logic signed [pdd_pkg::PiQW-1:0]   pi_q;
  logic [pdd_pkg::SqW-1:0]           den;
  logic [pdd_pkg::RemW-1:0]          rem;
  logic [pdd_pkg::QuoW-1:0]          work;
  logic                              neg;
  logic signed [pdd_pkg::SumW-1:0]   dsum;
  logic [pdd_pkg::DriveW-1:0]        out_data;
  logic                              out_valid;

  logic signed [pdd_pkg::IntegW-1:0] integ_add;
  logic signed [pdd_pkg::IntegW-1:0] wlim_pos;
  logic signed [pdd_pkg::IntegW-1:0] wlim_neg;
  logic signed [pdd_pkg::IntegW-1:0] integ_next;
  logic signed [pdd_pkg::DiffW-1:0]  diff;
  logic signed [pdd_pkg::MulAW-1:0]  mul_a;
  logic signed [pdd_pkg::MulBW-1:0]  mul_b;
  logic signed [pdd_pkg::MulPW-1:0]  mul_p;
  logic signed [pdd_pkg::ProdDW-1:0] neg_d;
  logic [pdd_pkg::ProdDW-1:0]        mag_d;
  logic [pdd_pkg::RemW:0]            shifted;
  logic [pdd_pkg::RemW:0]            den_ext;
  logic [pdd_pkg::RemW:0]            sub;
  logic                              ge;
  logic signed [pdd_pkg::PiW-1:0]    pi_round;
  logic signed [pdd_pkg::QuoW:0]     quo_s;
  logic signed [pdd_pkg::QuoW:0]     dterm;
  logic signed [pdd_pkg::SumW-1:0]   olim_pos;
  logic signed [pdd_pkg::SumW-1:0]   olim_neg;
  logic signed [pdd_pkg::SumW-1:0]   clamped;
  logic signed [pdd_pkg::DriveW-1:0] out_lim_s;

  // integral update with windup clamp
  assign integ_add = integral + pdd_pkg::IntegW'(error_in);
  assign wlim_pos  = $signed({2'b00, cfg.windup_limit});
  assign wlim_neg  = -wlim_pos;

  always_comb begin
    if (integ_add > wlim_pos) begin
      integ_next = wlim_pos;
    end else if (integ_add < wlim_neg) begin
      integ_next = wlim_neg;
    end else begin
      integ_next = integ_add;
    end
  end

  assign diff = pdd_pkg::DiffW'(error_in) - pdd_pkg::DiffW'(last_error);

  // shared multiplier operand select
  always_comb begin
    case (cmd.sel)
      pdd_pkg::MUL_P: begin
        mul_a = pdd_pkg::MulAW'(e_reg);
        mul_b = pdd_pkg::MulBW'(cfg.gain_p);
      end
      pdd_pkg::MUL_I: begin
        mul_a = integral;
        mul_b = pdd_pkg::MulBW'(cfg.gain_i);
      end
      pdd_pkg::MUL_D: begin
        mul_a = pdd_pkg::MulAW'(cfg.gain_d);
        mul_b = d_reg;
      end
      pdd_pkg::MUL_SQ: begin
        mul_a = pdd_pkg::MulAW'(e_reg);
        mul_b = pdd_pkg::MulBW'(e_reg);
      end
      default: begin
        mul_a = pdd_pkg::MulAW'(e_reg);
        mul_b = pdd_pkg::MulBW'(cfg.gain_p);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // divider set-up and step
  assign neg_d   = -prod_d;
  assign mag_d   = prod_d[pdd_pkg::ProdDW-1] ? neg_d : prod_d;
  assign shifted = {rem, work[pdd_pkg::QuoW-1]};
  assign den_ext = {1'b0, den};
  assign ge      = (shifted >= den_ext);
  assign sub     = shifted - den_ext;

  assign pi_round = pi_sum + (pi_sum[pdd_pkg::PiW-1] ? pdd_pkg::PiW'(255) : pdd_pkg::PiW'(0));
  assign quo_s    = $signed({1'b0, work});
  assign dterm    = neg ? -quo_s : quo_s;

  assign olim_pos = $signed({{(pdd_pkg::SumW - pdd_pkg::LimW){1'b0}}, cfg.output_limit});
  assign olim_neg = -olim_pos;

  always_comb begin
    if (dsum > olim_pos) begin
      clamped = olim_pos;
    end else if (dsum < olim_neg) begin
      clamped = olim_neg;
    end else begin
      clamped = dsum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral   <= '0;
      last_error <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        pdd_pkg::CMD_LOAD: begin
          integral   <= integ_next;
          last_error <= error_in;
          e_reg      <= error_in;
          d_reg      <= diff;
        end
        pdd_pkg::CMD_CLEAR: begin
          last_error <= '0;
        end
        pdd_pkg::CMD_MUL: begin
          case (cmd.sel)
            pdd_pkg::MUL_P:  prod_p  <= mul_p[pdd_pkg::ProdPW-1:0];
            pdd_pkg::MUL_I:  prod_i  <= mul_p[pdd_pkg::ProdIW-1:0];
            pdd_pkg::MUL_D:  prod_d  <= mul_p[pdd_pkg::ProdDW-1:0];
            pdd_pkg::MUL_SQ: prod_sq <= mul_p[pdd_pkg::SqW-1:0];
            default:         prod_p  <= mul_p[pdd_pkg::ProdPW-1:0];
          endcase
        end
        pdd_pkg::CMD_DIV_INIT: begin
          pi_sum <= pdd_pkg::PiW'(prod_p) + pdd_pkg::PiW'(prod_i);
          neg    <= prod_d[pdd_pkg::ProdDW-1];
          rem    <= pdd_pkg::RemW'(mag_d[31:16]);
          work   <= {mag_d[15:0], 8'h00};
          den    <= prod_sq + pdd_pkg::SqW'(65536);
        end
        pdd_pkg::CMD_DIV_STEP: begin
          rem  <= ge ? sub[pdd_pkg::RemW-1:0] : shifted[pdd_pkg::RemW-1:0];
          work <= {work[pdd_pkg::QuoW-2:0], ge};
          pi_q <= pi_round[pdd_pkg::PiW-1:8];
        end
        pdd_pkg::CMD_SUM: begin
          dsum <= pdd_pkg::SumW'(pi_q) + pdd_pkg::SumW'(dterm);
        end
        pdd_pkg::CMD_FINISH: begin
          out_data  <= clamped[pdd_pkg::DriveW-1:0];
          out_valid <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign sts.out_full = out_valid;
  assign m_tvalid     = out_valid;
  assign m_tdata      = out_data;
  assign out_lim_s    = $signed({1'b0, cfg.output_limit});

  `PDD_ASSERT_IMPLY(a_drive_in_limit, clk, rst, m_tvalid, ($signed(m_tdata) <= out_lim_s) && ($signed(m_tdata) >= -out_lim_s), "drive outside output limit")
  `PDD_ASSERT_IMPLY(a_finish_when_free, clk, rst, cmd.op == pdd_pkg::CMD_FINISH, !out_valid, "result overwrites pending transaction")

endmodule

[rtl/pdd_ctrl.sv]
// Controller FSM: sequences load, four multiplies, divider steps, sum and output.
// Depends on pdd_pkg and assert_macros.svh; drives pdd_dp through cmd_t.
`include "assert_macros.svh"

module pdd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  logic           s_tuser,
  output logic           s_tready,
  output pdd_pkg::cmd_t  cmd,
  input  pdd_pkg::sts_t  sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_SUM,
    ST_DONE
  } state_t;

  state_t                    state;
  logic [pdd_pkg::CntW-1:0]  cnt;
  logic                      ready;
  logic                      accept;

  assign accept   = s_tvalid && ready;
  assign s_tready = ready;

  always_comb begin
    cmd.op  = pdd_pkg::CMD_IDLE;
    cmd.sel = pdd_pkg::MUL_P;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.op = (s_tuser == pdd_pkg::OP_CLEAR) ? pdd_pkg::CMD_CLEAR : pdd_pkg::CMD_LOAD;
        end
      end
      ST_MUL: begin
        cmd.op  = pdd_pkg::CMD_MUL;
        cmd.sel = pdd_pkg::mul_sel_t'(cnt[1:0]);
      end
      ST_DIV_INIT: cmd.op = pdd_pkg::CMD_DIV_INIT;
      ST_DIV:      cmd.op = pdd_pkg::CMD_DIV_STEP;
      ST_SUM:      cmd.op = pdd_pkg::CMD_SUM;
      ST_DONE: begin
        if (!sts.out_full) begin
          cmd.op = pdd_pkg::CMD_FINISH;
        end
      end
      default: cmd.op = pdd_pkg::CMD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      ready <= 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && s_tuser == pdd_pkg::OP_SAMPLE) begin
            state <= ST_MUL;
            cnt   <= '0;
            ready <= 1'b0;
          end
        end
        ST_MUL: begin
          if (cnt == pdd_pkg::MulLast) begin
            state <= ST_DIV_INIT;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DIV_INIT: begin
          state <= ST_DIV;
          cnt   <= '0;
        end
        ST_DIV: begin
          if (cnt == pdd_pkg::DivLast) begin
            state <= ST_SUM;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_SUM: state <= ST_DONE;
        ST_DONE: begin
          if (!sts.out_full) begin
            state <= ST_IDLE;
            ready <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
          ready <= 1'b1;
        end
      endcase
    end
  end

  `PDD_ASSERT_IMPLY(a_ready_only_idle, clk, rst, ready, state == ST_IDLE, "ready outside idle")
  `PDD_ASSERT_NEXT(a_busy_after_sample, clk, rst, accept && s_tuser == pdd_pkg::OP_SAMPLE, !ready, "sample transaction did not start work")
  `PDD_ASSERT_NEXT(a_div_to_sum, clk, rst, state == ST_DIV && cnt == pdd_pkg::DivLast, cmd.op == pdd_pkg::CMD_SUM, "divider step count wrong")

endmodule

[rtl/pid_damped_derivative_unit.sv]
// Positional PID, integral clamp, derivative damped by 1/(1+e*e); APB registers.
// Depends on pdd_pkg, pdd_ctrl and pdd_dp.
// Drive is valid after the multiply, divider and sum steps, once the output register is free.
// No new sample is accepted until that result is registered; each sample passes through
// the 24-step restoring divider and four times through the shared multiplier; a clear stays in idle.
// Reset (synchronous): gains 0, both limits at full scale, integral and previous error 0.
module pid_damped_derivative_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pdd_pkg::AddrW-1:0]     paddr,
  input  logic [pdd_pkg::DataW-1:0]     pwdata,
  output logic [pdd_pkg::DataW-1:0]     prdata,
  output logic                          pready,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [pdd_pkg::ErrW-1:0]      s_tdata,   // [15:0] error_in
  input  logic                          s_tuser,   // [0] op
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [pdd_pkg::DriveW-1:0]    m_tdata    // [23:0] drive
);

  typedef enum logic [2:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_OUTPUT_LIMIT,
    REG_WINDUP_LIMIT
  } reg_idx_t;

  pdd_pkg::cfg_t  cfg;
  pdd_pkg::cmd_t  cmd;
  pdd_pkg::sts_t  sts;
  reg_idx_t       idx;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p       <= '0;
      cfg.gain_i       <= '0;
      cfg.gain_d       <= '0;
      cfg.output_limit <= pdd_pkg::LimReset;
      cfg.windup_limit <= pdd_pkg::LimReset;
    end else if (wr_en) begin
      case (idx)
        REG_GAIN_P:       cfg.gain_p       <= pwdata[pdd_pkg::GainW-1:0];
        REG_GAIN_I:       cfg.gain_i       <= pwdata[pdd_pkg::GainW-1:0];
        REG_GAIN_D:       cfg.gain_d       <= pwdata[pdd_pkg::GainW-1:0];
        REG_OUTPUT_LIMIT: cfg.output_limit <= pwdata[pdd_pkg::LimW-1:0];
        REG_WINDUP_LIMIT: cfg.windup_limit <= pwdata[pdd_pkg::LimW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN_P:       prdata = pdd_pkg::DataW'(unsigned'(cfg.gain_p));
      REG_GAIN_I:       prdata = pdd_pkg::DataW'(unsigned'(cfg.gain_i));
      REG_GAIN_D:       prdata = pdd_pkg::DataW'(unsigned'(cfg.gain_d));
      REG_OUTPUT_LIMIT: prdata = pdd_pkg::DataW'(cfg.output_limit);
      REG_WINDUP_LIMIT: prdata = pdd_pkg::DataW'(cfg.windup_limit);
      default:          prdata = '0;
    endcase
  end

  pdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  pdd_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .cfg      (cfg),
    .error_in ($signed(s_tdata)),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
